// File: hw/rtl/plc_pkg.sv
// Shared types and codes for the positional character list engine.
package plc_pkg;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_DEL   = 2'd1,
		REQ_GET   = 2'd2,
		REQ_PRINT = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		COP_HOLD  = 3'd0,
		COP_INS   = 3'd1,
		COP_DEL   = 3'd2,
		COP_LOAD  = 3'd3,
		COP_SHIFT = 3'd4
	} cell_op_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_SCAN = 1'b1
	} fsm_t;

	// broadcast to every cell; k is the zero-based target index
	typedef struct packed {
		cell_op_t    op;
		logic [7:0]  k;
		logic [7:0]  ch;
	} cell_ctl_t;

endpackage

// File: hw/rtl/positional_char_list_engine.sv
// Top level: chain of list cells driven by the request sequencer.
// Add, delete and requests with a bad rank go straight into the output register when taken.
// Get at rank r: load, r-1 readout shifts toward cell 0, then the output register.
// Print of n characters: n beats, one beat per cycle while out_ready holds.
// One request in flight at a time; a new one is taken once the last beat is registered and the output is free.
// Reset clears the length and control state; stored characters stay undefined.
module positional_char_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] position,
	input  logic [7:0] new_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic       has_char,
	output logic [7:0] char_out,
	output logic       last
);

	plc_pkg::cell_ctl_t ctl;
	logic [7:0] chars [CAPACITY];
	logic [7:0] rds   [CAPACITY];

	plc_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.position  (position),
		.new_char  (new_char),
		.head_rd   (rds[0]),
		.ctl       (ctl),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.has_char  (has_char),
		.char_out  (char_out),
		.last      (last)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [7:0] left_c, right_c, right_r;
		if (i == 0) begin : g_first
			assign left_c = 8'd0;
		end else begin : g_mid_l
			assign left_c = chars[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_c = 8'd0;
			assign right_r = 8'd0;
		end else begin : g_mid_r
			assign right_c = chars[i+1];
			assign right_r = rds[i+1];
		end
		plc_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.left_char  (left_c),
			.right_char (right_c),
			.right_rd   (right_r),
			.ctl        (ctl),
			.char_q     (chars[i]),
			.rd_q       (rds[i])
		);
	end

endmodule

// File: hw/rtl/plc_cell.sv
// One storage cell of the list chain with its readout stage.
module plc_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic [7:0]        left_char,
	input  logic [7:0]        right_char,
	input  logic [7:0]        right_rd,
	input  plc_pkg::cell_ctl_t ctl,
	output logic [7:0]        char_q,
	output logic [7:0]        rd_q
);

	logic at_or_above;
	logic at_target;

	assign at_or_above = IDX >= int'(ctl.k);
	assign at_target   = IDX == int'(ctl.k);

	always_ff @(posedge clk) begin
		case (ctl.op)
			plc_pkg::COP_INS: begin
				if (at_target) begin
					char_q <= ctl.ch;
				end else if (at_or_above) begin
					char_q <= left_char;
				end
			end
			plc_pkg::COP_DEL: begin
				if (at_or_above) begin
					char_q <= right_char;
				end
			end
			default: begin
			end
		endcase
	end

	// readout chain moves toward cell 0
	always_ff @(posedge clk) begin
		case (ctl.op)
			plc_pkg::COP_LOAD:  rd_q <= char_q;
			plc_pkg::COP_SHIFT: rd_q <= right_rd;
			default: begin
			end
		endcase
	end

endmodule

// File: hw/rtl/plc_ctrl.sv
// Request decoder, length counter, readout sequencer and output register.
module plc_ctrl #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [7:0]         position,
	input  logic [7:0]         new_char,
	input  logic [7:0]         head_rd,
	output plc_pkg::cell_ctl_t ctl,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic               has_char,
	output logic [7:0]         char_out,
	output logic               last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW + 1 > 9) ? CW + 1 : 9;

	plc_pkg::fsm_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          mode_q, mode_d;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic          has_q;
	logic [7:0]    char_q;
	logic          last_q;

	logic          in_acc, out_free;
	logic [MW-1:0] rank_x, n_x;
	logic          bad_add, bad_rd, full, empty;
	logic          ld;
	logic [1:0]    st_v;
	logic          has_v, last_v;
	logic [7:0]    ch_v;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == plc_pkg::FSM_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;

	assign rank_x  = MW'(position);
	assign n_x     = MW'(count_q);
	assign bad_add = (position == 8'd0) || (rank_x > n_x + MW'(1));
	assign bad_rd  = (position == 8'd0) || (rank_x > n_x);
	assign full    = count_q == CW'(CAPACITY);
	assign empty   = count_q == '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plc_pkg::FSM_IDLE: begin
				if (in_acc) begin
					if ((plc_pkg::req_t'(req_type) == plc_pkg::REQ_GET && !bad_rd) ||
					    (plc_pkg::req_t'(req_type) == plc_pkg::REQ_PRINT && !empty)) begin
						state_d = plc_pkg::FSM_SCAN;
					end
				end
			end
			plc_pkg::FSM_SCAN: begin
				if (!mode_q) begin
					if (cnt_q == '0 && out_free) begin
						state_d = plc_pkg::FSM_IDLE;
					end
				end else if (out_free && cnt_q == CW'(1)) begin
					state_d = plc_pkg::FSM_IDLE;
				end
			end
			default: state_d = plc_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		ctl.op  = plc_pkg::COP_HOLD;
		ctl.k   = position - 8'd1;
		ctl.ch  = new_char;
		count_d = count_q;
		cnt_d   = cnt_q;
		mode_d  = mode_q;
		ld      = 1'b0;
		st_v    = plc_pkg::ST_OK;
		has_v   = 1'b0;
		ch_v    = 8'd0;
		last_v  = 1'b1;
		unique case (state_q)
			plc_pkg::FSM_IDLE: begin
				if (in_acc) begin
					unique case (plc_pkg::req_t'(req_type))
						plc_pkg::REQ_ADD: begin
							ld = 1'b1;
							if (bad_add) begin
								st_v = plc_pkg::ST_BAD_POS;
							end else if (full) begin
								st_v = plc_pkg::ST_FULL;
							end else begin
								ctl.op  = plc_pkg::COP_INS;
								count_d = count_q + CW'(1);
							end
						end
						plc_pkg::REQ_DEL: begin
							ld = 1'b1;
							if (bad_rd) begin
								st_v = plc_pkg::ST_BAD_POS;
							end else begin
								ctl.op  = plc_pkg::COP_DEL;
								count_d = count_q - CW'(1);
							end
						end
						plc_pkg::REQ_GET: begin
							if (bad_rd) begin
								ld   = 1'b1;
								st_v = plc_pkg::ST_BAD_POS;
							end else begin
								ctl.op = plc_pkg::COP_LOAD;
								cnt_d  = CW'(rank_x - MW'(1));
								mode_d = 1'b0;
							end
						end
						plc_pkg::REQ_PRINT: begin
							if (empty) begin
								ld = 1'b1;
							end else begin
								ctl.op = plc_pkg::COP_LOAD;
								cnt_d  = count_q;
								mode_d = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			plc_pkg::FSM_SCAN: begin
				if (!mode_q) begin
					if (cnt_q == '0) begin
						if (out_free) begin
							ld    = 1'b1;
							has_v = 1'b1;
							ch_v  = head_rd;
						end
					end else begin
						ctl.op = plc_pkg::COP_SHIFT;
						cnt_d  = cnt_q - CW'(1);
					end
				end else if (out_free) begin
					ld     = 1'b1;
					has_v  = 1'b1;
					ch_v   = head_rd;
					last_v = cnt_q == CW'(1);
					ctl.op = plc_pkg::COP_SHIFT;
					cnt_d  = cnt_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plc_pkg::FSM_IDLE;
			count_q     <= '0;
			cnt_q       <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			cnt_q   <= cnt_d;
			mode_q  <= mode_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			status_q <= st_v;
			has_q    <= has_v;
			char_q   <= ch_v;
			last_q   <= last_v;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign has_char  = has_q;
	assign char_out  = char_q;
	assign last      = last_q;

endmodule

// File: tb/sv/tb.sv
// Testbench for the positional character list engine: directed and random requests, scoreboarded.
`timescale 1ns / 1ps

module tb;

	localparam int CAPACITY = 64;
	localparam int CYCLE_LIMIT = 1_500_000;

	typedef struct packed {
		plc_pkg::status_t st;
		logic             has;
		logic [7:0]       ch;
		logic             last;
	} beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] req_type = plc_pkg::REQ_ADD;
	logic [7:0] position = 8'd0;
	logic [7:0] new_char = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic       has_char;
	logic [7:0] char_out;
	logic       last;

	logic [7:0] list_chars [CAPACITY];
	int         list_len = 0;
	beat_t      pending_beats [$];
	int         errors = 0;
	int         cycle_count = 0;
	bit         tx_idle = 1'b1;
	bit         rx_idle = 1'b1;
	int         rx_hold_cycles = 0;

	positional_char_list_engine #(.CAPACITY(CAPACITY)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.position  (position),
		.new_char  (new_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.has_char  (has_char),
		.char_out  (char_out),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL positional_char_list_engine");
		$finish;
	end

	function automatic beat_t mk_beat(plc_pkg::status_t st, logic has, logic [7:0] ch,
		logic lst);
		beat_t b;
		b.st = st;
		b.has = has;
		b.ch = ch;
		b.last = lst;
		return b;
	endfunction

	// list behavior: updates the mirror and queues the beats this request produces
	task automatic apply_request(input plc_pkg::req_t op, input logic [7:0] pos,
		input logic [7:0] ch);
		int r;
		r = pos;
		case (op)
			plc_pkg::REQ_ADD: begin
				if (r < 1 || r > list_len + 1)
					pending_beats.push_back(mk_beat(plc_pkg::ST_BAD_POS, 1'b0, 8'd0, 1'b1));
				else if (list_len >= CAPACITY)
					pending_beats.push_back(mk_beat(plc_pkg::ST_FULL, 1'b0, 8'd0, 1'b1));
				else begin
					for (int i = list_len; i > r - 1; i--)
						list_chars[i] = list_chars[i - 1];
					list_chars[r - 1] = ch;
					list_len++;
					pending_beats.push_back(mk_beat(plc_pkg::ST_OK, 1'b0, 8'd0, 1'b1));
				end
			end
			plc_pkg::REQ_DEL: begin
				if (r < 1 || r > list_len)
					pending_beats.push_back(mk_beat(plc_pkg::ST_BAD_POS, 1'b0, 8'd0, 1'b1));
				else begin
					for (int i = r - 1; i + 1 < list_len; i++)
						list_chars[i] = list_chars[i + 1];
					list_len--;
					pending_beats.push_back(mk_beat(plc_pkg::ST_OK, 1'b0, 8'd0, 1'b1));
				end
			end
			plc_pkg::REQ_GET: begin
				if (r < 1 || r > list_len)
					pending_beats.push_back(mk_beat(plc_pkg::ST_BAD_POS, 1'b0, 8'd0, 1'b1));
				else
					pending_beats.push_back(mk_beat(plc_pkg::ST_OK, 1'b1, list_chars[r - 1],
						1'b1));
			end
			default: begin
				if (list_len == 0)
					pending_beats.push_back(mk_beat(plc_pkg::ST_OK, 1'b0, 8'd0, 1'b1));
				else
					for (int i = 0; i < list_len; i++)
						pending_beats.push_back(mk_beat(plc_pkg::ST_OK, 1'b1, list_chars[i],
							i + 1 == list_len));
			end
		endcase
	endtask

	task automatic send_req(input plc_pkg::req_t op, input logic [7:0] pos,
		input logic [7:0] ch);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		position <= pos;
		new_char <= ch;
		do @(posedge clk); while (!in_ready);
		apply_request(op, pos, ch);
	endtask

	task automatic wait_list_quiet();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_rank(int hi);
		if (hi >= 1 && $urandom_range(0, 9) < 8)
			return 8'($urandom_range(1, hi));
		return 8'($urandom_range(0, 255));
	endfunction

	// beat sink with random stalls and an occasional long hold-off
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else
				stall = rx_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat status=%0d has=%0b char=%02h last=%0b",
					$time, status, has_char, char_out, last);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				if (status !== want.st) begin
					$display("%0t: status exp %0d got %0d", $time, want.st, status);
					errors++;
				end
				if (has_char !== want.has) begin
					$display("%0t: has_char exp %0b got %0b", $time, want.has, has_char);
					errors++;
				end
				if (char_out !== want.ch) begin
					$display("%0t: char_out exp %02h got %02h", $time, want.ch, char_out);
					errors++;
				end
				if (last !== want.last) begin
					$display("%0t: last exp %0b got %0b", $time, want.last, last);
					errors++;
				end
			end
		end
	end

	task automatic test_empty_list();
		send_req(plc_pkg::REQ_PRINT, 8'h00, 8'h00);
		send_req(plc_pkg::REQ_GET, 8'd1, 8'h00);
		send_req(plc_pkg::REQ_DEL, 8'd1, 8'h00);
		send_req(plc_pkg::REQ_GET, 8'd0, 8'h00);
		send_req(plc_pkg::REQ_ADD, 8'd0, 8'h11);
		send_req(plc_pkg::REQ_ADD, 8'd2, 8'h22);
		send_req(plc_pkg::REQ_PRINT, 8'hFF, 8'hFF);
		wait_list_quiet();
	endtask

	task automatic test_basic_edits();
		send_req(plc_pkg::REQ_ADD, 8'd1, 8'h00);
		send_req(plc_pkg::REQ_ADD, 8'd2, 8'hFF);
		send_req(plc_pkg::REQ_ADD, 8'd1, 8'hA5);
		send_req(plc_pkg::REQ_ADD, 8'd3, 8'h5A);
		send_req(plc_pkg::REQ_ADD, 8'd255, 8'h77);
		send_req(plc_pkg::REQ_GET, 8'd1, 8'hFF);
		send_req(plc_pkg::REQ_GET, 8'd4, 8'h00);
		send_req(plc_pkg::REQ_GET, 8'd5, 8'h00);
		send_req(plc_pkg::REQ_GET, 8'd255, 8'h00);
		send_req(plc_pkg::REQ_DEL, 8'd0, 8'h00);
		send_req(plc_pkg::REQ_DEL, 8'd255, 8'h00);
		send_req(plc_pkg::REQ_DEL, 8'd2, 8'h00);
		send_req(plc_pkg::REQ_DEL, 8'd3, 8'h00);
		send_req(plc_pkg::REQ_PRINT, 8'd0, 8'h00);
		send_req(plc_pkg::REQ_DEL, 8'd1, 8'h00);
		send_req(plc_pkg::REQ_DEL, 8'd1, 8'h00);
		send_req(plc_pkg::REQ_PRINT, 8'h80, 8'h80);
		wait_list_quiet();
	endtask

	// receiver holds off while requests keep coming back to back
	task automatic test_backpressure();
		tx_idle = 1'b0;
		for (int i = 0; i < 4; i++)
			send_req(plc_pkg::REQ_ADD, 8'($urandom_range(1, list_len + 1)), 8'($urandom));
		rx_hold_cycles = 300;
		send_req(plc_pkg::REQ_PRINT, 8'd0, 8'd0);
		for (int i = 0; i < 8; i++)
			send_req(plc_pkg::REQ_GET, pick_rank(list_len), 8'($urandom));
		send_req(plc_pkg::REQ_PRINT, 8'd0, 8'd0);
		send_req(plc_pkg::REQ_DEL, pick_rank(list_len), 8'd0);
		tx_idle = 1'b1;
		wait_list_quiet();
	endtask

	task automatic test_fill_to_capacity();
		rx_idle = 1'b0;
		while (list_len < CAPACITY)
			send_req(plc_pkg::REQ_ADD, 8'($urandom_range(1, list_len + 1)), 8'($urandom));
		rx_idle = 1'b1;
		send_req(plc_pkg::REQ_ADD, 8'(CAPACITY + 1), 8'($urandom));
		send_req(plc_pkg::REQ_ADD, 8'(CAPACITY + 2), 8'($urandom));
		send_req(plc_pkg::REQ_ADD, 8'd0, 8'($urandom));
		send_req(plc_pkg::REQ_ADD, 8'd1, 8'($urandom));
		send_req(plc_pkg::REQ_GET, 8'(CAPACITY), 8'd0);
		send_req(plc_pkg::REQ_GET, 8'(CAPACITY + 1), 8'd0);
		send_req(plc_pkg::REQ_PRINT, 8'($urandom), 8'($urandom));
		while (list_len > 40)
			send_req(plc_pkg::REQ_DEL, 8'($urandom_range(1, list_len)), 8'($urandom));
		send_req(plc_pkg::REQ_PRINT, 8'd0, 8'd0);
		wait_list_quiet();
	endtask

	task automatic test_random_ops(input int count);
		int            roll;
		int            add_pct;
		plc_pkg::req_t op;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				tx_idle = $urandom_range(0, 2) != 0;
				rx_idle = $urandom_range(0, 2) != 0;
			end
			add_pct = (list_len > 48) ? 25 : (list_len < 4) ? 50 : 40;
			roll = $urandom_range(0, 99);
			if (roll < add_pct)
				op = plc_pkg::REQ_ADD;
			else if (roll < add_pct + 30)
				op = plc_pkg::REQ_DEL;
			else if (roll < 92)
				op = plc_pkg::REQ_GET;
			else
				op = plc_pkg::REQ_PRINT;
			send_req(op, pick_rank(op == plc_pkg::REQ_ADD ? list_len + 1 : list_len),
				8'($urandom));
		end
		wait_list_quiet();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_basic_edits();
		test_backpressure();
		test_fill_to_capacity();
		test_random_ops(200);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS positional_char_list_engine");
		else
			$display("FAIL positional_char_list_engine");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/plc_pkg.sv
hw/rtl/plc_cell.sv
hw/rtl/plc_ctrl.sv
hw/rtl/positional_char_list_engine.sv
tb/sv/tb.sv
